// ----- rtl/mrte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_pkg
// Shared types and function codes for the R-type execute core.
// ----------------------------------------------------------------------------
package mrte_pkg;

  localparam int unsigned XLEN  = 32;
  localparam int unsigned RIDXW = 5;
  localparam int unsigned CNTW  = 6;

  // Function codes.
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADFN  = 2'd1;
  localparam logic [1:0] ST_DIVZ   = 2'd2;

  localparam logic [RIDXW-1:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic              req_type;
    logic [XLEN-1:0]   instr_word;
    logic [XLEN-1:0]   cur_pc;
    logic [RIDXW-1:0]  load_index;
    logic [XLEN-1:0]   load_value;
  } in_beat_t;

  typedef struct packed {
    logic              wr_en;
    logic [RIDXW-1:0]  wr_index;
    logic [XLEN-1:0]   wr_value;
    logic              jump;
    logic [XLEN-1:0]   next_pc;
    logic [XLEN-1:0]   hi_value;
    logic [XLEN-1:0]   lo_value;
    logic [1:0]        status;
  } out_beat_t;

  // Control from the sequencer to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
  } md_ctl_t;

  // Status returned by the shared unit.
  typedef struct packed {
    logic done;
  } md_sts_t;

endpackage

// ----- rtl/mrte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_in_if / mrte_out_if
// Valid/ready channels for input and result beats.
// ----------------------------------------------------------------------------
interface mrte_in_if import mrte_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrte_out_if import mrte_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mrte_muldiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrte_muldiv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module mrte_muldiv import mrte_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  md_ctl_t         ctl,
  input  logic [XLEN-1:0] op_a,
  input  logic [XLEN-1:0] op_b,
  output md_sts_t         sts,
  output logic [XLEN-1:0] res_hi,
  output logic [XLEN-1:0] res_lo
);

  logic            busy_r, busy_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            div_r, div_nxt;
  logic            neg_q_r, neg_q_nxt;
  logic            neg_r_r, neg_r_nxt;
  logic [XLEN-1:0] acc_r, acc_nxt;   // product high half / remainder
  logic [XLEN-1:0] sh_r, sh_nxt;     // multiplier and low product / quotient
  logic [XLEN-1:0] dv_r, dv_nxt;     // multiplicand or divisor magnitude
  logic            fin_r, fin_nxt;

  logic [XLEN-1:0] mag_a, mag_b;
  logic [XLEN:0]   add_sum;
  logic [XLEN:0]   trial;
  logic [XLEN-1:0] q_out, r_out;

  assign mag_a = (ctl.is_signed && op_a[XLEN-1]) ? (~op_a + 1'b1) : op_a;
  assign mag_b = (ctl.is_signed && op_b[XLEN-1]) ? (~op_b + 1'b1) : op_b;

  // Two adders: an add for multiply and a trial subtract for divide.
  assign add_sum = {1'b0, acc_r} + {1'b0, dv_r};
  assign trial   = {acc_r, sh_r[XLEN-1]} - {1'b0, dv_r};

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    dv_nxt    = dv_r;
    fin_nxt   = 1'b0;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      div_nxt   = ctl.is_div;
      neg_q_nxt = ctl.is_signed && (op_a[XLEN-1] ^ op_b[XLEN-1]);
      neg_r_nxt = ctl.is_signed && op_a[XLEN-1];
      acc_nxt   = '0;
      sh_nxt    = mag_a;
      dv_nxt    = mag_b;
    end else if (busy_r) begin
      if (div_r) begin
        if (!trial[XLEN]) begin
          acc_nxt = trial[XLEN-1:0];
          sh_nxt  = {sh_r[XLEN-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[XLEN-2:0], sh_r[XLEN-1]};
          sh_nxt  = {sh_r[XLEN-2:0], 1'b0};
        end
      end else begin
        if (sh_r[0]) begin
          {acc_nxt, sh_nxt} = {add_sum, sh_r[XLEN-1:1]};
        end else begin
          {acc_nxt, sh_nxt} = {1'b0, acc_r, sh_r[XLEN-1:1]};
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(XLEN - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r   <= cnt_nxt;
    div_r   <= div_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    acc_r   <= acc_nxt;
    sh_r    <= sh_nxt;
    dv_r    <= dv_nxt;
  end

  // Sign correction on the way out; the product's signs are fixed the same way.
  logic [2*XLEN-1:0] prod;
  assign prod  = neg_q_r ? (~{acc_r, sh_r} + 1'b1) : {acc_r, sh_r};
  assign q_out = neg_q_r ? (~sh_r + 1'b1) : sh_r;
  assign r_out = neg_r_r ? (~acc_r + 1'b1) : acc_r;

  assign sts.done = fin_r;
  assign res_hi   = div_r ? r_out : prod[2*XLEN-1:XLEN];
  assign res_lo   = div_r ? q_out : prod[XLEN-1:0];

endmodule

// ----- rtl/mips_r_type_execute_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_r_type_execute_core
// Executes MIPS32 R-type instructions against a register file and HI/LO.
// ----------------------------------------------------------------------------
// One beat at a time. A load or an operation other than mult, multu, div and
// divu is executed in S_EXEC and its result is registered for S_OUT; those four
// run through a shared one-bit-per-cycle multiply/divide unit in S_MD, except
// that a divide by zero skips the unit and goes from S_EXEC to S_OUT. The block
// accepts no new beat until the result of the previous one has been taken.
module mips_r_type_execute_core import mrte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mrte_in_if.sink    in_ch,
  mrte_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  in_beat_t        req_r;
  logic [XLEN-1:0] rf_r [32];
  logic [31:1]     rf_vld_r;
  logic [XLEN-1:0] hi_r, lo_r;
  out_beat_t       res_r, res_nxt;
  logic            hilo_we;
  logic [XLEN-1:0] hi_nxt, lo_nxt;
  logic            rf_we;

  logic [RIDXW-1:0] rs, rt, rd, sh;
  logic [5:0]       fn;
  logic [XLEN-1:0]  a, b;
  md_ctl_t          md_ctl;
  md_sts_t          md_sts;
  logic [XLEN-1:0]  md_hi, md_lo;

  assign rs = req_r.instr_word[25:21];
  assign rt = req_r.instr_word[20:16];
  assign rd = req_r.instr_word[15:11];
  assign sh = req_r.instr_word[10:6];
  assign fn = req_r.instr_word[5:0];
  assign a  = (rs != '0 && rf_vld_r[rs]) ? rf_r[rs] : '0;
  assign b  = (rt != '0 && rf_vld_r[rt]) ? rf_r[rt] : '0;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  mrte_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .ctl(md_ctl), .op_a(a), .op_b(b),
    .sts(md_sts), .res_hi(md_hi), .res_lo(md_lo)
  );

  // Decode, execute and next-state logic.
  always_comb begin
    logic            wr;
    logic [RIDXW-1:0] widx;
    logic [XLEN-1:0] wval;
    wr        = 1'b0;
    widx      = rd;
    wval      = '0;
    state_nxt = state_r;
    res_nxt   = res_r;
    md_ctl    = '0;
    hilo_we   = 1'b0;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rf_we     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_nxt = '0;
        res_nxt.status = ST_OK;
        state_nxt = S_OUT;
        if (req_r.req_type) begin
          wr = 1'b1; widx = req_r.load_index; wval = req_r.load_value;
        end else begin
          unique case (fn) inside
            FN_SLL:  begin wr = 1'b1; wval = b << sh; end
            FN_SRL:  begin wr = 1'b1; wval = b >> sh; end
            FN_SRA:  begin wr = 1'b1; wval = XLEN'($signed(b) >>> sh); end
            FN_SLLV: begin wr = 1'b1; wval = b << a[4:0]; end
            FN_SRLV: begin wr = 1'b1; wval = b >> a[4:0]; end
            FN_SRAV: begin wr = 1'b1; wval = XLEN'($signed(b) >>> a[4:0]); end
            FN_JR:   begin res_nxt.jump = 1'b1; res_nxt.next_pc = a; end
            FN_JALR: begin
              res_nxt.jump = 1'b1; res_nxt.next_pc = a;
              wr = 1'b1; widx = LINK_REG; wval = req_r.cur_pc + 32'd4;
            end
            FN_MFHI: begin wr = 1'b1; wval = hi_r; end
            FN_MFLO: begin wr = 1'b1; wval = lo_r; end
            FN_MULT, FN_MULTU: begin
              md_ctl.start = 1'b1; md_ctl.is_signed = (fn == FN_MULT);
              state_nxt = S_MD;
            end
            FN_DIV, FN_DIVU: begin
              if (b == '0) begin
                res_nxt.status = ST_DIVZ;
              end else begin
                md_ctl.start = 1'b1; md_ctl.is_div = 1'b1;
                md_ctl.is_signed = (fn == FN_DIV);
                state_nxt = S_MD;
              end
            end
            FN_ADD, FN_ADDU: begin wr = 1'b1; wval = a + b; end
            FN_SUB, FN_SUBU: begin wr = 1'b1; wval = a - b; end
            FN_AND:  begin wr = 1'b1; wval = a & b; end
            FN_OR:   begin wr = 1'b1; wval = a | b; end
            FN_XOR:  begin wr = 1'b1; wval = a ^ b; end
            FN_NOR:  begin wr = 1'b1; wval = ~(a | b); end
            FN_SLT:  begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin wr = 1'b1; wval = {31'd0, a < b}; end
            default: res_nxt.status = ST_BADFN;
          endcase
        end
        if (wr && widx != '0) begin
          rf_we = 1'b1;
          res_nxt.wr_en = 1'b1; res_nxt.wr_index = widx; res_nxt.wr_value = wval;
        end
        res_nxt.hi_value = hi_r;
        res_nxt.lo_value = lo_r;
      end
      S_MD: begin
        if (md_sts.done) begin
          hilo_we = 1'b1; hi_nxt = md_hi; lo_nxt = md_lo;
          res_nxt.hi_value = md_hi; res_nxt.lo_value = md_lo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, register file, HI/LO, request and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rf_vld_r <= '0;
      hi_r     <= '0;
      lo_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (rf_we) rf_vld_r[res_nxt.wr_index] <= 1'b1;
      if (hilo_we) begin
        hi_r <= hi_nxt;
        lo_r <= lo_nxt;
      end
    end
    if (rf_we) rf_r[res_nxt.wr_index] <= res_nxt.wr_value;
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    res_r <= res_nxt;
  end

endmodule

// ----- verif/tb_mips_r_type_execute_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_r_type_execute_core
// Self-checking bench for the R-type execute core: a directed table of
// instruction and load beats, then random programs, checked field by field
// against a register-file and HI/LO model kept in the bench.
// ----------------------------------------------------------------------------
module tb_mips_r_type_execute_core;
  import mrte_pkg::*;

  logic clk;
  logic rst_n;

  mrte_in_if  in_ch ();
  mrte_out_if out_ch ();

  mips_r_type_execute_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Model state and the queue of predicted result beats.
  logic [31:0] gpr [32];
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  out_beat_t   pending_wb [$];
  int          errors;
  bit          hold_off;
  bit          no_idle;

  // Directed table: the beat, and a typed-in result where it is obvious.
  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t res;
  } row_t;
  row_t dir_rows [$];

  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
    return {6'd0, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] sra32(logic [31:0] x, logic [4:0] s);
    return $unsigned($signed(x) >>> s);
  endfunction

  // Predict one beat and advance the model state.
  function automatic out_beat_t execute_beat(in_beat_t b);
    out_beat_t   o;
    logic [4:0]  rs, rt, rd, sh;
    logic [5:0]  fn;
    logic [31:0] a, v, q, r, ma, mb;
    logic [63:0] p;
    bit          wr;
    o = '0;
    wr = 0;
    v = '0;
    if (b.req_type) begin
      wr = 1;
      rd = b.load_index;
      v = b.load_value;
    end else begin
      rs = b.instr_word[25:21];
      rt = b.instr_word[20:16];
      rd = b.instr_word[15:11];
      sh = b.instr_word[10:6];
      fn = b.instr_word[5:0];
      a = gpr[rs];
      v = gpr[rt];
      case (fn)
        FN_SLL:  begin wr = 1; v = v << sh; end
        FN_SRL:  begin wr = 1; v = v >> sh; end
        FN_SRA:  begin wr = 1; v = sra32(v, sh); end
        FN_SLLV: begin wr = 1; v = v << a[4:0]; end
        FN_SRLV: begin wr = 1; v = v >> a[4:0]; end
        FN_SRAV: begin wr = 1; v = sra32(v, a[4:0]); end
        FN_JR:   begin o.jump = 1; o.next_pc = a; end
        FN_JALR: begin
          o.jump = 1; o.next_pc = a; wr = 1; rd = LINK_REG; v = b.cur_pc + 32'd4;
        end
        FN_MFHI: begin wr = 1; v = hi_q; end
        FN_MFLO: begin wr = 1; v = lo_q; end
        FN_MULT: begin
          p = $unsigned(64'($signed(a)) * 64'($signed(v)));
          hi_q = p[63:32]; lo_q = p[31:0];
        end
        FN_MULTU: begin
          p = {32'd0, a} * {32'd0, v};
          hi_q = p[63:32]; lo_q = p[31:0];
        end
        FN_DIV: begin
          if (v == 0) o.status = ST_DIVZ;
          else begin
            ma = a[31] ? -a : a;
            mb = v[31] ? -v : v;
            q = ma / mb;
            r = ma % mb;
            lo_q = (a[31] != v[31]) ? -q : q;
            hi_q = a[31] ? -r : r;
          end
        end
        FN_DIVU: begin
          if (v == 0) o.status = ST_DIVZ;
          else begin lo_q = a / v; hi_q = a % v; end
        end
        FN_ADD, FN_ADDU: begin wr = 1; v = a + v; end
        FN_SUB, FN_SUBU: begin wr = 1; v = a - v; end
        FN_AND:  begin wr = 1; v = a & v; end
        FN_OR:   begin wr = 1; v = a | v; end
        FN_XOR:  begin wr = 1; v = a ^ v; end
        FN_NOR:  begin wr = 1; v = ~(a | v); end
        FN_SLT:  begin wr = 1; v = {31'd0, $signed(a) < $signed(v)}; end
        FN_SLTU: begin wr = 1; v = {31'd0, a < v}; end
        default: o.status = ST_BADFN;
      endcase
    end
    if (wr && rd != 0) begin
      gpr[rd] = v;
      o.wr_en = 1; o.wr_index = rd; o.wr_value = v;
    end
    o.hi_value = hi_q;
    o.lo_value = lo_q;
    return o;
  endfunction

  function automatic in_beat_t load_beat(logic [4:0] idx, logic [31:0] val);
    in_beat_t b;
    b = '0;
    b.req_type = 1; b.load_index = idx; b.load_value = val;
    b.instr_word = $urandom; b.cur_pc = $urandom;
    return b;
  endfunction

  function automatic in_beat_t exec_beat(logic [31:0] iw, logic [31:0] pc);
    in_beat_t b;
    b = '0;
    b.instr_word = iw; b.cur_pc = pc;
    b.load_index = 5'($urandom); b.load_value = $urandom;
    return b;
  endfunction

  function automatic logic [5:0] pick_fn();
    logic [5:0] fl [24];
    fl = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
           FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU,
           FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    return fl[$urandom_range(23)];
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(in_beat_t b, bit fixed, out_beat_t res);
    row_t r;
    r.beat = b; r.fixed = fixed; r.res = res;
    dir_rows.push_back(r);
  endtask

  // Drive one beat and wait for its acceptance. Valid stays high after the
  // handshake so that a following beat can go out in the same step; any
  // pause drops it first.
  task automatic send_beat(in_beat_t b, bit fixed, out_beat_t res);
    out_beat_t pred;
    if (!no_idle && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    pred = execute_beat(b);
    if (fixed && pred != res) begin
      $error("table row disagrees with model: exp %h model %h", res, pred);
      errors++;
    end
    pending_wb.push_back(pred);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random ready, with one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
    end
  end

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    out_beat_t e, g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (pending_wb.size() == 0) begin
        $error("result beat with nothing expected: %h", g);
        errors++;
      end else begin
        e = pending_wb.pop_front();
        if (g.wr_en !== e.wr_en) begin
          $error("wr_en exp %h got %h", e.wr_en, g.wr_en); errors++; end
        if (g.wr_index !== e.wr_index) begin
          $error("wr_index exp %h got %h", e.wr_index, g.wr_index); errors++; end
        if (g.wr_value !== e.wr_value) begin
          $error("wr_value exp %h got %h", e.wr_value, g.wr_value); errors++; end
        if (g.jump !== e.jump) begin
          $error("jump exp %h got %h", e.jump, g.jump); errors++; end
        if (g.next_pc !== e.next_pc) begin
          $error("next_pc exp %h got %h", e.next_pc, g.next_pc); errors++; end
        if (g.hi_value !== e.hi_value) begin
          $error("hi_value exp %h got %h", e.hi_value, g.hi_value); errors++; end
        if (g.lo_value !== e.lo_value) begin
          $error("lo_value exp %h got %h", e.lo_value, g.lo_value); errors++; end
        if (g.status !== e.status) begin
          $error("status exp %h got %h", e.status, g.status); errors++; end
      end
    end
  end

  // Watchdog.
  initial begin
    #(100_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus.
  initial begin
    out_beat_t z;
    in_beat_t  b;
    int        n, k;
    logic [4:0] rs, rt;
    errors = 0; hold_off = 0; no_idle = 0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0; lo_q = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    z = '0;
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD), 32'h0), 1,
            '{1'b1, 5'd3, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, ST_OK});
    add_row(load_beat(5'd0, 32'hFFFF_FFFF), 1, z);
    add_row(exec_beat(r_word(5'd0, 5'd0, 5'd4, 5'd0, 6'h0C), 32'h0), 1,
            '{1'b0, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, ST_BADFN});
    add_row(exec_beat(r_word(5'd5, 5'd0, 5'd0, 5'd0, FN_DIV), 32'h0), 1,
            '{1'b0, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, ST_DIVZ});
    add_row(load_beat(5'd31, 32'hFFFF_FFFF), 1,
            '{1'b1, 5'd31, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0, ST_OK});
    add_row(load_beat(5'd1, 32'h8000_0000), 0, z);
    add_row(load_beat(5'd2, 32'hFFFF_FFFF), 0, z);
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd2, 5'd1, 5'd3, 5'd31, FN_SRA), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd2, 5'd1, 5'd3, 5'd31, FN_SRL), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd3, 5'd31, FN_SLL), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd4, 5'd0, FN_SLT), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd4, 5'd0, FN_SLTU), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd1, 5'd2, 5'd0, 5'd0, FN_MULTU), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd0, 5'd0, 5'd6, 5'd0, FN_MFLO), 32'h0), 0, z);
    add_row(load_beat(5'd7, 32'hFFFF_FFF9), 0, z);
    add_row(load_beat(5'd8, 32'd2), 0, z);
    add_row(exec_beat(r_word(5'd7, 5'd8, 5'd0, 5'd0, FN_DIV), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd7, 5'd8, 5'd0, 5'd0, FN_DIVU), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd8, 5'd2, 5'd9, 5'd0, FN_SRAV), 32'h0), 0, z);
    add_row(exec_beat(r_word(5'd31, 5'd0, 5'd0, 5'd0, FN_JALR), 32'hFFFF_FFFC), 0, z);
    add_row(exec_beat(r_word(5'd31, 5'd0, 5'd0, 5'd0, FN_JR), 32'h0), 0, z);
    add_row(exec_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, z);
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].res);

    // Random program: loads, operations on random registers and random words.
    for (n = 0; n < 500; n++) begin
      if (n == 150 && pending_wb.size() != 0) begin
        // Sender pauses until the result side has drained.
        in_ch.valid <= 1'b0;
        while (pending_wb.size() != 0) @(posedge clk);
      end
      if (n == 200) begin
        // Receiver holds off for a counted stretch while beats keep coming.
        hold_off = 1;
        fork
          begin repeat (60) @(posedge clk); hold_off = 0; end
        join_none
      end
      if (n == 300) no_idle = 1;
      if (n == 360) no_idle = 0;
      k = $urandom_range(99);
      if (k < 30) begin
        b = load_beat(5'($urandom), rand_val());
      end else if (k < 92) begin
        rs = 5'($urandom); rt = 5'($urandom);
        b = exec_beat({6'($urandom), rs, rt, 5'($urandom), 5'($urandom), pick_fn()},
                      $urandom);
      end else begin
        b = exec_beat($urandom, $urandom);
      end
      send_beat(b, 0, z);
    end
    in_ch.valid <= 1'b0;
    hold_off = 0;

    k = 0;
    while (pending_wb.size() != 0 && k < 10000) begin
      @(posedge clk);
      k++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_wb.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
